>>> rtl/core/wpp_pkg.sv
// Types and constants shared by the WAVE PCM stream parser modules.
package wpp_pkg;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_REM = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic        start;
    arith_op_e   op;
    logic [31:0] opa;
    logic [15:0] opb;
  } arith_req_t;

  typedef struct packed {
    logic        res_valid;
    logic        busy;
    logic [31:0] result;
  } arith_rsp_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_ERROR  = 2'd1,
    KIND_HEADER = 2'd2
  } kind_e;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_ID        = 4'd1;
  localparam logic [3:0] ERR_WAVE      = 4'd2;
  localparam logic [3:0] ERR_FMT_TAG   = 4'd3;
  localparam logic [3:0] ERR_NOT_PCM   = 4'd4;
  localparam logic [3:0] ERR_FMT_SHORT = 4'd5;
  localparam logic [3:0] ERR_NO_CHAN   = 4'd6;
  localparam logic [3:0] ERR_BITS      = 4'd7;
  localparam logic [3:0] ERR_BYTE_RATE = 4'd8;
  localparam logic [3:0] ERR_ALIGN     = 4'd9;
  localparam logic [3:0] ERR_DATA_TAG  = 4'd10;
  localparam logic [3:0] ERR_RIFF_SIZE = 4'd11;
  localparam logic [3:0] ERR_PARTIAL   = 4'd12;
  localparam logic [3:0] ERR_EMPTY     = 4'd13;
  localparam logic [3:0] ERR_TRUNC     = 4'd14;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

endpackage

>>> rtl/core/wpp_arith.sv
// Shared shift-add multiplier and restoring remainder unit, one bit per cycle.
module wpp_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wpp_pkg::arith_req_t req_i,
  output wpp_pkg::arith_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               rvld_q, rvld_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [31:0]        acc_q, acc_d;
  logic [31:0]        sh_q, sh_d;
  logic [15:0]        bb_q, bb_d;
  wpp_pkg::arith_op_e op_q, op_d;
  logic [16:0]        trial;
  logic [31:0]        add_a, add_b;
  logic [32:0]        sum;
  logic [4:0]         last_cnt;

  assign trial    = {acc_q[15:0], sh_q[31]};
  assign add_a    = (op_q == wpp_pkg::OP_MUL) ? acc_q : {15'd0, trial};
  assign add_b    = (op_q == wpp_pkg::OP_MUL) ? (bb_q[0] ? sh_q : 32'd0)
                                              : ~{16'd0, bb_q};
  assign sum      = {1'b0, add_a} + {1'b0, add_b} +
                    {32'd0, (op_q == wpp_pkg::OP_REM)};
  assign last_cnt = (op_q == wpp_pkg::OP_MUL) ? 5'd15 : 5'd31;

  always_comb begin
    busy_d = busy_q;
    rvld_d = rvld_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    bb_d   = bb_q;
    op_d   = op_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rvld_d = 1'b0;
      cnt_d  = 5'd0;
      acc_d  = 32'd0;
      sh_d   = req_i.opa;
      bb_d   = req_i.opb;
      op_d   = req_i.op;
    end else if (busy_q) begin
      cnt_d = cnt_q + 5'd1;
      sh_d  = {sh_q[30:0], 1'b0};
      if (op_q == wpp_pkg::OP_MUL) begin
        acc_d = sum[31:0];
        bb_d  = {1'b0, bb_q[15:1]};
      end else begin
        acc_d = sum[32] ? {15'd0, sum[16:0]} : {15'd0, trial};
      end
      if (cnt_q == last_cnt) begin
        busy_d = 1'b0;
        rvld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rvld_q <= 1'b0;
      cnt_q  <= 5'd0;
      op_q   <= wpp_pkg::OP_MUL;
    end else begin
      busy_q <= busy_d;
      rvld_q <= rvld_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    bb_q  <= bb_d;
  end

  assign rsp_o.res_valid = rvld_q;
  assign rsp_o.busy      = busy_q;
  assign rsp_o.result    = acc_q;

endmodule

>>> rtl/core/wave_pcm_stream_parser_top.sv
// Top level: byte sequencer of the WAVE PCM stream parser.
// Header and sample bytes: one byte per cycle while the output is taken.
// A result is registered and appears in the cycle after the byte or check step that causes it.
// The last format byte stalls input for a 16-step shift-add in the shared unit and
// until the output is free; the last data size byte stalls it likewise for a 32-step remainder.
// Reset (rst_ni low, asynchronous) returns the parser to expect a chunk id.
module wave_pcm_stream_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_file_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] sample_value_o,
  output logic [15:0]        channel_index_o,
  output logic [31:0]        frame_index_o,
  output logic [31:0]        sample_rate_out_o,
  output logic [5:0]         sample_bits_o,
  output logic [3:0]         error_code_o,
  output logic               last_sample_o
);

  typedef enum logic [10:0] {
    PH_ID      = 11'b000_0000_0001,
    PH_RSIZE   = 11'b000_0000_0010,
    PH_WAVE    = 11'b000_0000_0100,
    PH_FMTTAG  = 11'b000_0000_1000,
    PH_FMTSIZE = 11'b000_0001_0000,
    PH_BODY    = 11'b000_0010_0000,
    PH_SKIP    = 11'b000_0100_0000,
    PH_DATATAG = 11'b000_1000_0000,
    PH_DSIZE   = 11'b001_0000_0000,
    PH_SAMPLES = 11'b010_0000_0000,
    PH_DONE    = 11'b100_0000_0000
  } phase_e;

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_MUL = 3'b010,
    ST_REM = 3'b100
  } seq_e;

  phase_e      phase_q, phase_d;
  seq_e        seq_q, seq_d;
  logic [31:0] bc_q, bc_d;
  logic        be_q, be_d;
  logic [31:0] gw_q, gw_d;
  logic [31:0] riff_q, riff_d;
  logic [31:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] brate_q, brate_d;
  logic [15:0] align_q, align_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] drem_q, drem_d;
  logic [15:0] ccnt_q, ccnt_d;
  logic [31:0] fcnt_q, fcnt_d;
  logic        halt_q, halt_d;
  logic        pcm_q, pcm_d;

  logic               ov_q, ov_d;
  logic [1:0]         kind_q, kind_d;
  logic signed [31:0] smp_q, smp_d;
  logic [15:0]        ch_q, ch_d;
  logic [31:0]        fr_q, fr_d;
  logic [31:0]        ro_q, ro_d;
  logic [5:0]         sb_q, sb_d;
  logic [3:0]         ec_q, ec_d;
  logic               ls_q, ls_d;

  wpp_pkg::arith_req_t req;
  wpp_pkg::arith_rsp_t rsp;

  logic        accept, out_free, load;
  logic [31:0] gw_n, bc_n, n32, bpe32, prod_sh, riff_sum;
  logic [15:0] n16;
  logic [17:0] align_need;
  logic [2:0]  bps;

  wpp_arith u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (seq_q != ST_RUN) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign gw_n = {gw_q[23:0], data_byte_i};
  assign bc_n = bc_q + 32'd1;
  assign n16  = be_q ? gw_n[15:0] : {gw_n[7:0], gw_n[15:8]};
  assign n32  = be_q ? gw_n : {gw_n[7:0], gw_n[15:8], gw_n[23:16], gw_n[31:24]};
  assign bps  = bits_q[5:3];
  assign bpe32 = {29'd0, bps};
  assign align_need = {2'b00, chan_q} * {15'd0, bps};
  assign prod_sh = (bps == 3'd4) ? {rsp.result[29:0], 2'b00} :
                   (bps == 3'd2) ? {rsp.result[30:0], 1'b0} : rsp.result;
  assign riff_sum = 32'd20 + fmt_q + n32;

  always_comb begin
    phase_d = phase_q;  seq_d = seq_q;    bc_d = bc_q;       be_d = be_q;
    gw_d = gw_q;        riff_d = riff_q;  fmt_d = fmt_q;     chan_d = chan_q;
    rate_d = rate_q;    brate_d = brate_q; align_d = align_q; bits_d = bits_q;
    drem_d = drem_q;    ccnt_d = ccnt_q;  fcnt_d = fcnt_q;   halt_d = halt_q;
    pcm_d = pcm_q;
    load = 1'b0;
    kind_d = kind_q;    smp_d = smp_q;    ch_d = ch_q;       fr_d = fr_q;
    ro_d = ro_q;        sb_d = sb_q;      ec_d = ec_q;       ls_d = ls_q;
    req.start = 1'b0;
    req.op    = wpp_pkg::OP_MUL;
    req.opa   = rate_q;
    req.opb   = chan_q;

    unique case (seq_q)
      ST_RUN: begin
        if (accept && !halt_q && phase_q != PH_DONE) begin
          if (end_of_file_i) begin
            load = 1'b1; kind_d = wpp_pkg::KIND_ERROR; ec_d = wpp_pkg::ERR_TRUNC;
            halt_d = 1'b1;
          end else begin
            gw_d = gw_n;
            bc_d = bc_n;
            unique case (phase_q)
              PH_ID: begin
                if (bc_n == 32'd4) begin
                  priority if (gw_n == wpp_pkg::TAG_RIFF) begin
                    be_d = 1'b0; bc_d = 32'd0; phase_d = PH_RSIZE;
                  end else if (gw_n == wpp_pkg::TAG_RIFX) begin
                    be_d = 1'b1; bc_d = 32'd0; phase_d = PH_RSIZE;
                  end else begin
                    load = 1'b1; kind_d = wpp_pkg::KIND_ERROR;
                    ec_d = wpp_pkg::ERR_ID; halt_d = 1'b1;
                  end
                end
              end
              PH_RSIZE: begin
                if (bc_n == 32'd4) begin
                  riff_d = n32; bc_d = 32'd0; phase_d = PH_WAVE;
                end
              end
              PH_WAVE: begin
                if (bc_n == 32'd4) begin
                  if (gw_n != wpp_pkg::TAG_WAVE) begin
                    load = 1'b1; kind_d = wpp_pkg::KIND_ERROR;
                    ec_d = wpp_pkg::ERR_WAVE; halt_d = 1'b1;
                  end else begin
                    bc_d = 32'd0; phase_d = PH_FMTTAG;
                  end
                end
              end
              PH_FMTTAG: begin
                if (bc_n == 32'd4) begin
                  if (gw_n != wpp_pkg::TAG_FMT) begin
                    load = 1'b1; kind_d = wpp_pkg::KIND_ERROR;
                    ec_d = wpp_pkg::ERR_FMT_TAG; halt_d = 1'b1;
                  end else begin
                    bc_d = 32'd0; phase_d = PH_FMTSIZE;
                  end
                end
              end
              PH_FMTSIZE: begin
                if (bc_n == 32'd4) begin
                  fmt_d = n32; bc_d = 32'd0; phase_d = PH_BODY;
                end
              end
              PH_BODY: begin
                if (bc_n == 32'd2)  pcm_d = (n16 == 16'd1);
                if (bc_n == 32'd4)  chan_d = n16;
                if (bc_n == 32'd8)  rate_d = n32;
                if (bc_n == 32'd12) brate_d = n32;
                if (bc_n == 32'd14) align_d = n16;
                if (bc_n == 32'd16) begin
                  bits_d = n16;
                  req.start = 1'b1;
                  seq_d = ST_MUL;
                end
              end
              PH_SKIP: begin
                if (bc_n >= fmt_q - 32'd16) begin
                  bc_d = 32'd0; phase_d = PH_DATATAG;
                end
              end
              PH_DATATAG: begin
                if (bc_n == 32'd4) begin
                  if (gw_n != wpp_pkg::TAG_DATA) begin
                    load = 1'b1; kind_d = wpp_pkg::KIND_ERROR;
                    ec_d = wpp_pkg::ERR_DATA_TAG; halt_d = 1'b1;
                  end else begin
                    bc_d = 32'd0; phase_d = PH_DSIZE;
                  end
                end
              end
              PH_DSIZE: begin
                if (bc_n == 32'd4) begin
                  drem_d = n32;
                  priority if (riff_q != riff_sum) begin
                    load = 1'b1; kind_d = wpp_pkg::KIND_ERROR;
                    ec_d = wpp_pkg::ERR_RIFF_SIZE; halt_d = 1'b1;
                  end else if (align_q == 16'd0) begin
                    load = 1'b1; kind_d = wpp_pkg::KIND_ERROR;
                    ec_d = wpp_pkg::ERR_PARTIAL; halt_d = 1'b1;
                  end else begin
                    req.start = 1'b1;
                    req.op    = wpp_pkg::OP_REM;
                    req.opa   = n32;
                    req.opb   = align_q;
                    seq_d     = ST_REM;
                  end
                end
              end
              PH_SAMPLES: begin
                drem_d = drem_q - 32'd1;
                if (bc_n >= bpe32) begin
                  bc_d = 32'd0;
                  load = 1'b1;
                  kind_d = wpp_pkg::KIND_SAMPLE;
                  ec_d = wpp_pkg::ERR_NONE;
                  ro_d = 32'd0; sb_d = 6'd0;
                  priority if (bps == 3'd1) smp_d = {{24{gw_n[7]}}, gw_n[7:0]};
                  else if (bps == 3'd2) smp_d = {{16{n16[15]}}, n16};
                  else smp_d = n32;
                  ch_d = ccnt_q;
                  fr_d = fcnt_q;
                  if (ccnt_q + 16'd1 >= chan_q) begin
                    ccnt_d = 16'd0; fcnt_d = fcnt_q + 32'd1;
                  end else begin
                    ccnt_d = ccnt_q + 16'd1;
                  end
                  ls_d = (drem_q == 32'd1);
                  if (drem_q == 32'd1) phase_d = PH_DONE;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_MUL: begin
        if (rsp.res_valid && out_free) begin
          seq_d = ST_RUN;
          kind_d = wpp_pkg::KIND_ERROR;
          priority if (!pcm_q) begin
            load = 1'b1; ec_d = wpp_pkg::ERR_NOT_PCM;
          end else if (fmt_q < 32'd16) begin
            load = 1'b1; ec_d = wpp_pkg::ERR_FMT_SHORT;
          end else if (chan_q == 16'd0) begin
            load = 1'b1; ec_d = wpp_pkg::ERR_NO_CHAN;
          end else if (bits_q != 16'd8 && bits_q != 16'd16 && bits_q != 16'd32) begin
            load = 1'b1; ec_d = wpp_pkg::ERR_BITS;
          end else if (brate_q != prod_sh) begin
            load = 1'b1; ec_d = wpp_pkg::ERR_BYTE_RATE;
          end else if ({2'b00, align_q} != align_need) begin
            load = 1'b1; ec_d = wpp_pkg::ERR_ALIGN;
          end else begin
            bc_d = 32'd0;
            phase_d = (fmt_q > 32'd16) ? PH_SKIP : PH_DATATAG;
          end
          if (load) halt_d = 1'b1;
        end
      end
      ST_REM: begin
        if (rsp.res_valid && out_free) begin
          seq_d = ST_RUN;
          load = 1'b1;
          priority if (rsp.result != 32'd0) begin
            kind_d = wpp_pkg::KIND_ERROR; ec_d = wpp_pkg::ERR_PARTIAL; halt_d = 1'b1;
          end else if (drem_q == 32'd0) begin
            kind_d = wpp_pkg::KIND_ERROR; ec_d = wpp_pkg::ERR_EMPTY; halt_d = 1'b1;
          end else begin
            kind_d = wpp_pkg::KIND_HEADER; ec_d = wpp_pkg::ERR_NONE;
            ch_d = chan_q; ro_d = rate_q; sb_d = bits_q[5:0];
            bc_d = 32'd0; ccnt_d = 16'd0; fcnt_d = 32'd0;
            phase_d = PH_SAMPLES;
          end
        end
      end
      default: seq_d = ST_RUN;
    endcase

    if (load && kind_d != wpp_pkg::KIND_SAMPLE) begin
      smp_d = 32'sd0; fr_d = 32'd0; ls_d = 1'b0;
      if (kind_d == wpp_pkg::KIND_ERROR) begin
        ch_d = 16'd0; ro_d = 32'd0; sb_d = 6'd0;
      end
    end

    priority if (load) ov_d = 1'b1;
    else if (!out_stall_i) ov_d = 1'b0;
    else ov_d = ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;   seq_q <= ST_RUN;  bc_q <= 32'd0;   be_q <= 1'b0;
      gw_q <= 32'd0;      riff_q <= 32'd0;  fmt_q <= 32'd0;  chan_q <= 16'd0;
      rate_q <= 32'd0;    brate_q <= 32'd0; align_q <= 16'd0; bits_q <= 16'd0;
      drem_q <= 32'd0;    ccnt_q <= 16'd0;  fcnt_q <= 32'd0; halt_q <= 1'b0;
      pcm_q <= 1'b0;      ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; seq_q <= seq_d;   bc_q <= bc_d;    be_q <= be_d;
      gw_q <= gw_d;       riff_q <= riff_d; fmt_q <= fmt_d;  chan_q <= chan_d;
      rate_q <= rate_d;   brate_q <= brate_d; align_q <= align_d; bits_q <= bits_d;
      drem_q <= drem_d;   ccnt_q <= ccnt_d; fcnt_q <= fcnt_d; halt_q <= halt_d;
      pcm_q <= pcm_d;     ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d; smp_q <= smp_d; ch_q <= ch_d; fr_q <= fr_d;
      ro_q <= ro_d;     sb_q <= sb_d;   ec_q <= ec_d; ls_q <= ls_d;
    end
  end

  assign out_valid_o       = ov_q;
  assign kind_o            = kind_q;
  assign sample_value_o    = smp_q;
  assign channel_index_o   = ch_q;
  assign frame_index_o     = fr_q;
  assign sample_rate_out_o = ro_q;
  assign sample_bits_o     = sb_q;
  assign error_code_o      = ec_q;
  assign last_sample_o     = ls_q;

endmodule

>>> rtl/core/wpp_checker.sv
// Port-level assertions for the WAVE PCM stream parser, bound to the top level.
module wpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [15:0] channel_index_o,
  input logic [5:0]  sample_bits_o,
  input logic [3:0]  error_code_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o))
    else $error("output beat dropped while stalled");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == wpp_pkg::KIND_ERROR |-> error_code_o != wpp_pkg::ERR_NONE)
    else $error("error beat without code");

  a_err_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && kind_o == wpp_pkg::KIND_ERROR |=> !out_valid_o)
    else $error("beat after error report");

  a_hdr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == wpp_pkg::KIND_HEADER |->
      channel_index_o != 16'd0 &&
      (sample_bits_o == 6'd8 || sample_bits_o == 6'd16 || sample_bits_o == 6'd32))
    else $error("header beat with bad format");

endmodule

bind wave_pcm_stream_parser_top wpp_checker u_wpp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .channel_index_o(channel_index_o),
  .sample_bits_o  (sample_bits_o),
  .error_code_o   (error_code_o)
);

>>> tb/tb_top.sv
// Self-checking testbench for the WAVE PCM stream parser: one file per reset.
module tb_top;

  typedef enum int {
    P_ID, P_RSIZE, P_WAVE, P_FMTTAG, P_FMTSIZE, P_BODY, P_SKIP, P_DATATAG,
    P_DSIZE, P_SAMPLES, P_DONE
  } parse_phase_e;

  typedef struct {
    wpp_pkg::kind_e     kind;
    logic signed [31:0] value;
    logic [15:0]        chan;
    logic [31:0]        frame;
    logic [31:0]        rate;
    logic [5:0]         bits;
    logic [3:0]         err;
    logic               last;
  } wave_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] data_byte_i = 8'd0;
  logic end_of_file_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic signed [31:0] sample_value_o;
  logic [15:0] channel_index_o;
  logic [31:0] frame_index_o;
  logic [31:0] sample_rate_out_o;
  logic [5:0] sample_bits_o;
  logic [3:0] error_code_o;
  logic last_sample_o;

  wave_pcm_stream_parser_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  wave_result_t pending_results[$];
  int failures = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  // parser mirror
  parse_phase_e ph = P_ID;
  logic [31:0] cnt = 0, gw = 0, riff_len = 0, fmt_len = 0, rate_v = 0, brate_v = 0;
  logic [31:0] data_left = 0, frame_ctr = 0, chans = 0, align_v = 0, bits_v = 0;
  logic [31:0] chan_ctr = 0;
  bit be = 0, halted = 0, pcm_ok = 0;

  function automatic logic [31:0] word16();
    logic [31:0] v;
    v = gw & 32'hFFFF;
    if (!be) v = {16'd0, v[7:0], v[15:8]};
    return v;
  endfunction

  function automatic logic [31:0] word32();
    return be ? gw : {gw[7:0], gw[15:8], gw[23:16], gw[31:24]};
  endfunction

  function automatic bit halt_with(logic [3:0] code, ref wave_result_t r);
    halted = 1;
    r.kind = wpp_pkg::KIND_ERROR;
    r.err = code;
    return 1;
  endfunction

  function automatic bit parse_beat(logic [7:0] b, logic eof, ref wave_result_t r);
    logic [31:0] bps, raw;
    r = '{wpp_pkg::KIND_SAMPLE, 0, 0, 0, 0, 0, wpp_pkg::ERR_NONE, 0};
    if (halted || ph == P_DONE) return 0;
    if (eof) return halt_with(wpp_pkg::ERR_TRUNC, r);
    gw = {gw[23:0], b};
    cnt++;
    case (ph)
      P_ID: begin
        if (cnt < 4) return 0;
        if (gw == wpp_pkg::TAG_RIFF) be = 0;
        else if (gw == wpp_pkg::TAG_RIFX) be = 1;
        else return halt_with(wpp_pkg::ERR_ID, r);
      end
      P_RSIZE: begin
        if (cnt < 4) return 0;
        riff_len = word32();
      end
      P_WAVE: begin
        if (cnt < 4) return 0;
        if (gw != wpp_pkg::TAG_WAVE) return halt_with(wpp_pkg::ERR_WAVE, r);
      end
      P_FMTTAG: begin
        if (cnt < 4) return 0;
        if (gw != wpp_pkg::TAG_FMT) return halt_with(wpp_pkg::ERR_FMT_TAG, r);
      end
      P_FMTSIZE: begin
        if (cnt < 4) return 0;
        fmt_len = word32();
      end
      P_BODY: begin
        case (cnt)
          2: begin pcm_ok = (word16() == 1); return 0; end
          4: begin chans = word16(); return 0; end
          8: begin rate_v = word32(); return 0; end
          12: begin brate_v = word32(); return 0; end
          14: begin align_v = word16(); return 0; end
          16: bits_v = word16();
          default: return 0;
        endcase
        bps = bits_v / 8;
        if (!pcm_ok) return halt_with(wpp_pkg::ERR_NOT_PCM, r);
        if (fmt_len < 16) return halt_with(wpp_pkg::ERR_FMT_SHORT, r);
        if (chans == 0) return halt_with(wpp_pkg::ERR_NO_CHAN, r);
        if (bits_v != 8 && bits_v != 16 && bits_v != 32)
          return halt_with(wpp_pkg::ERR_BITS, r);
        if (brate_v != rate_v * chans * bps) return halt_with(wpp_pkg::ERR_BYTE_RATE, r);
        if (align_v != chans * bps) return halt_with(wpp_pkg::ERR_ALIGN, r);
        cnt = 0;
        ph = (fmt_len > 16) ? P_SKIP : P_DATATAG;
        return 0;
      end
      P_SKIP: if (cnt < fmt_len - 16) return 0;
      P_DATATAG: begin
        if (cnt < 4) return 0;
        if (gw != wpp_pkg::TAG_DATA) return halt_with(wpp_pkg::ERR_DATA_TAG, r);
      end
      P_DSIZE: begin
        if (cnt < 4) return 0;
        data_left = word32();
        if (riff_len != 32'd20 + fmt_len + data_left)
          return halt_with(wpp_pkg::ERR_RIFF_SIZE, r);
        if (align_v == 0 || data_left % align_v != 0)
          return halt_with(wpp_pkg::ERR_PARTIAL, r);
        if (data_left == 0) return halt_with(wpp_pkg::ERR_EMPTY, r);
        cnt = 0;
        chan_ctr = 0;
        frame_ctr = 0;
        ph = P_SAMPLES;
        r.kind = wpp_pkg::KIND_HEADER;
        r.chan = chans[15:0];
        r.rate = rate_v;
        r.bits = bits_v[5:0];
        return 1;
      end
      P_SAMPLES: begin
        bps = bits_v / 8;
        data_left--;
        if (cnt < bps) return 0;
        cnt = 0;
        if (bps == 1) raw = {{24{gw[7]}}, gw[7:0]};
        else if (bps == 2) begin
          raw = word16();
          raw = {{16{raw[15]}}, raw[15:0]};
        end else raw = word32();
        r.value = raw;
        r.chan = chan_ctr[15:0];
        r.frame = frame_ctr;
        chan_ctr++;
        if (chan_ctr >= chans) begin
          chan_ctr = 0;
          frame_ctr++;
        end
        if (data_left == 0) begin
          r.last = 1;
          ph = P_DONE;
        end
        return 1;
      end
      default: return 0;
    endcase
    cnt = 0;
    ph = parse_phase_e'(ph + 1);
    return 0;
  endfunction

  task automatic send_beat(logic [7:0] b, logic eof = 1'b0);
    wave_result_t r;
    bit st;
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_file_i <= eof;
    do begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
    end while (st);
    if (parse_beat(b, eof, r)) pending_results.push_back(r);
  endtask

  task automatic send_tag(logic [31:0] tag);
    for (int i = 3; i >= 0; i--) send_beat(tag[i*8 +: 8]);
  endtask

  // file layout shared by the test tasks
  bit file_be, truncate;
  int n_chan, n_bytes, fmt_extra, data_len;
  logic [31:0] rate_pick;

  task automatic send_num(logic [31:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++)
      send_beat(v[(file_be ? nbytes - 1 - i : i) * 8 +: 8]);
  endtask

  task automatic test_header();
    int frames;
    file_be = 1'($urandom_range(1));
    n_chan = ($urandom_range(9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    n_bytes = 1 << $urandom_range(2);
    fmt_extra = $urandom_range(3);
    rate_pick = $urandom();
    frames = 1200 / (n_chan * n_bytes);
    data_len = frames * n_chan * n_bytes;
    send_tag(file_be ? wpp_pkg::TAG_RIFX : wpp_pkg::TAG_RIFF);
    send_num(20 + 16 + fmt_extra + data_len, 4);
    send_tag(wpp_pkg::TAG_WAVE);
    send_tag(wpp_pkg::TAG_FMT);
    send_num(16 + fmt_extra, 4);
    send_num(1, 2);
    send_num(n_chan, 2);
    send_num(rate_pick, 4);
    send_num(rate_pick * n_chan * n_bytes, 4);
    send_num(n_chan * n_bytes, 2);
    send_num(n_bytes * 8, 2);
    for (int i = 0; i < fmt_extra; i++) send_beat(8'($urandom_range(255)));
    send_tag(wpp_pkg::TAG_DATA);
    send_num(data_len, 4);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic test_samples();
    logic [7:0] edge_bytes[4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    int stop_at;
    truncate = 1'($urandom_range(1));
    stop_at = truncate ? $urandom_range(data_len - 1) : data_len;
    for (int i = 0; i < stop_at; i++) begin
      calm = (i >= 300 && i < 500);
      send_beat(i < 4 ? edge_bytes[i] : 8'($urandom_range(255)));
    end
    calm = 1'b0;
  endtask

  task automatic test_tail();
    if (truncate) send_beat(8'($urandom_range(255)), 1'b1);
    for (int i = 0; i < 8; i++)
      send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i)
    out_stall_i <= !calm && ($urandom_range(99) < 35);

  always @(negedge clk_i) begin
    wave_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: kind %0d", kind_o);
        failures++;
      end else begin
        e = pending_results.pop_front();
        if (kind_o != e.kind) begin
          $error("kind exp %0d got %0d", e.kind, kind_o); failures++;
        end
        if (sample_value_o != e.value) begin
          $error("sample_value exp %0d got %0d", e.value, sample_value_o); failures++;
        end
        if (channel_index_o != e.chan) begin
          $error("channel_index exp %0d got %0d", e.chan, channel_index_o); failures++;
        end
        if (frame_index_o != e.frame) begin
          $error("frame_index exp %0d got %0d", e.frame, frame_index_o); failures++;
        end
        if (sample_rate_out_o != e.rate) begin
          $error("sample_rate_out exp %0d got %0d", e.rate, sample_rate_out_o); failures++;
        end
        if (sample_bits_o != e.bits) begin
          $error("sample_bits exp %0d got %0d", e.bits, sample_bits_o); failures++;
        end
        if (error_code_o != e.err) begin
          $error("error_code exp %0d got %0d", e.err, error_code_o); failures++;
        end
        if (last_sample_o != e.last) begin
          $error("last_sample exp %0d got %0d", e.last, last_sample_o); failures++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 3000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header();
    test_samples();
    test_tail();
    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk_i);
    if (failures == 0 && pending_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
